[hdl/garch_variance_recursion_top_defines.svh]
// ----------------------------------------------------------------------------
// GARCH variance recursion - assertion macros
// Shared macros for the concurrent checks of the variance block.
// ----------------------------------------------------------------------------
`ifndef GARCH_VARIANCE_RECURSION_TOP_DEFINES_SVH
`define GARCH_VARIANCE_RECURSION_TOP_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define GARV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that also holds during reset.
`define GARV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed during reset");

`endif

[hdl/garv_pkg.sv]
// ----------------------------------------------------------------------------
// GARCH variance recursion - package
// Payload types, register indexes and the microcode table of the sequencer.
// ----------------------------------------------------------------------------
package garv_pkg;

  localparam int NUM_COEF  = 3;
  localparam int FRAC_BITS = 15;
  localparam int VAR_W     = 32;
  localparam int COEF_W    = 16;
  localparam int RES_W     = 16;
  localparam int PROD_W    = COEF_W + VAR_W;
  localparam int ACC_W     = 52;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCH3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GARCH1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GARCH2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GARCH3 = 3'd6;

  typedef struct packed {
    logic signed [RES_W-1:0] residual;
    logic                    start_series;
  } garv_in_t;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic             saturated;
  } garv_out_t;

  // Condition a step waits on before it fires
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_IN     = 2'd1,
    COND_OUT    = 2'd2
  } cond_e;

  // Multiplier operand pair
  typedef enum logic [2:0] {
    MUL_SQUARE = 3'd0,
    MUL_ARCH1  = 3'd1,
    MUL_ARCH2  = 3'd2,
    MUL_ARCH3  = 3'd3,
    MUL_GARCH1 = 3'd4,
    MUL_GARCH2 = 3'd5,
    MUL_GARCH3 = 3'd6,
    MUL_NONE   = 3'd7
  } mul_sel_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_DONE = 2'd3
  } acc_op_e;

  typedef struct packed {
    cond_e             cond;
    mul_sel_e          mul_sel;
    acc_op_e           acc_op;
    logic              capt_sq;
    logic              jump;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    ctrl_word_t word;
    logic       fire;
  } garv_ctrl_t;

  localparam logic [STEP_W-1:0] STEP_START = 3'd0;

  // Microcode: one date per pass. The square is captured by the following step, and each weighted
  // product is accumulated by the following step; the last step rounds, clamps and retires.
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{cond: COND_ALWAYS, mul_sel: MUL_NONE, acc_op: ACC_HOLD,
          capt_sq: 1'b0, jump: 1'b0, target: STEP_START};
    unique case (step)
      3'd0: begin
        w.cond    = COND_IN;
        w.mul_sel = MUL_SQUARE;
        w.acc_op  = ACC_LOAD;
      end
      3'd1: begin
        w.mul_sel = MUL_ARCH1;
        w.capt_sq = 1'b1;
      end
      3'd2: begin
        w.mul_sel = MUL_ARCH2;
        w.acc_op  = ACC_ADD;
      end
      3'd3: begin
        w.mul_sel = MUL_ARCH3;
        w.acc_op  = ACC_ADD;
      end
      3'd4: begin
        w.mul_sel = MUL_GARCH1;
        w.acc_op  = ACC_ADD;
      end
      3'd5: begin
        w.mul_sel = MUL_GARCH2;
        w.acc_op  = ACC_ADD;
      end
      3'd6: begin
        w.mul_sel = MUL_GARCH3;
        w.acc_op  = ACC_ADD;
      end
      3'd7: begin
        w.cond   = COND_OUT;
        w.acc_op = ACC_DONE;
        w.jump   = 1'b1;
        w.target = STEP_START;
      end
      default: begin
        w.jump   = 1'b1;
        w.target = STEP_START;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/garch_variance_recursion_top.sv]
// The result of an accepted input appears on out_valid_o once the last microcode step retires it.
// No new input is taken until then; the single shared 16x32 multiplier forms the square
// and six weighted lags one per cycle, stepped by the microcode.
// Reset: asynchronous, active low; clears the configuration registers, delay lines,
// step counter and output valid.
// A stalled output holds the sequencer on its last step until the result is taken.
// ----------------------------------------------------------------------------
// GARCH variance recursion - top level
// GARCH(p,q) conditional variance, one residual in and one variance out.
// ----------------------------------------------------------------------------
module garch_variance_recursion_top #(
  parameter int ARCH_ORDER  = 3,
  parameter int GARCH_ORDER = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [garv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [garv_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  garv_pkg::garv_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output garv_pkg::garv_out_t           out_data_o
);
  import garv_pkg::*;

  garv_ctrl_t ctrl;
  garv_out_t  result;
  garv_out_t  out_data_q;
  logic       out_valid_q;
  logic       out_free;
  logic       done;

  assign out_free = !out_valid_q || out_ready_i;

  garv_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  garv_dp #(
    .ARCH_ORDER  (ARCH_ORDER),
    .GARCH_ORDER (GARCH_ORDER)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .in_data_i   (in_data_i),
    .result_o    (result),
    .done_o      (done)
  );

  // Output register: load on retire, drop once the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hdl/garv_seq.sv]
// ----------------------------------------------------------------------------
// GARCH variance recursion - microcode sequencer
// Step counter over the control table, with wait conditions and jumps.
// ----------------------------------------------------------------------------
module garv_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_free_i,
  output garv_pkg::garv_ctrl_t ctrl_o,
  output logic                in_ready_o
);
  import garv_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ctrl_word_t        word;
  logic              fire;

  assign word = ucode_rom(step_q);

  always_comb begin
    unique case (word.cond)
      COND_IN:  fire = in_valid_i;
      COND_OUT: fire = out_free_i;
      default:  fire = 1'b1;
    endcase
  end

  // Hold the step until its condition is met, then advance or jump
  always_comb begin
    step_d = step_q;
    if (fire) begin
      step_d = word.jump ? word.target : step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_START;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o = (word.cond == COND_IN);
  assign ctrl_o     = '{word: word, fire: fire};

endmodule

[hdl/garv_dp.sv]
// ----------------------------------------------------------------------------
// GARCH variance recursion - datapath
// Coefficient registers, delay lines, shared multiplier and accumulator.
// ----------------------------------------------------------------------------
module garv_dp #(
  parameter int ARCH_ORDER  = 3,
  parameter int GARCH_ORDER = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [garv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [garv_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  garv_pkg::garv_ctrl_t          ctrl_i,
  input  garv_pkg::garv_in_t            in_data_i,
  output garv_pkg::garv_out_t           result_o,
  output logic                          done_o
);
  import garv_pkg::*;

  logic [VAR_W-1:0]  omega_q;
  logic [COEF_W-1:0] arch_q  [NUM_COEF];
  logic [COEF_W-1:0] garch_q [NUM_COEF];

  logic [VAR_W-1:0]  sq_hist_q  [ARCH_ORDER];
  logic [VAR_W-1:0]  var_hist_q [GARCH_ORDER];
  logic [VAR_W-1:0]  sq_tap     [NUM_COEF];
  logic [VAR_W-1:0]  var_tap    [NUM_COEF];

  logic [RES_W-1:0]  res_u;
  logic [RES_W-1:0]  mag;
  logic [COEF_W-1:0] op_a;
  logic [VAR_W-1:0]  op_b;
  logic [PROD_W-1:0] prod_q;
  logic [VAR_W-1:0]  sq_new_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  sum;
  logic              sat;
  logic              clear_hist;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q <= '0;
      for (int k = 0; k < NUM_COEF; k++) begin
        arch_q[k]  <= '0;
        garch_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OMEGA:  omega_q    <= cfg_wdata_i[VAR_W-1:0];
        CFG_ARCH1:  arch_q[0]  <= cfg_wdata_i[COEF_W-1:0];
        CFG_ARCH2:  arch_q[1]  <= cfg_wdata_i[COEF_W-1:0];
        CFG_ARCH3:  arch_q[2]  <= cfg_wdata_i[COEF_W-1:0];
        CFG_GARCH1: garch_q[0] <= cfg_wdata_i[COEF_W-1:0];
        CFG_GARCH2: garch_q[1] <= cfg_wdata_i[COEF_W-1:0];
        CFG_GARCH3: garch_q[2] <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Lags beyond the delay-line depth read as zero
  for (genvar k = 0; k < NUM_COEF; k++) begin : g_tap
    if (k < ARCH_ORDER) begin : g_sq
      assign sq_tap[k] = sq_hist_q[k];
    end else begin : g_sq_zero
      assign sq_tap[k] = '0;
    end
    if (k < GARCH_ORDER) begin : g_var
      assign var_tap[k] = var_hist_q[k];
    end else begin : g_var_zero
      assign var_tap[k] = '0;
    end
  end

  assign res_u = RES_W'(in_data_i.residual);
  assign mag   = res_u[RES_W-1] ? (~res_u + RES_W'(1)) : res_u;

  always_comb begin
    case (ctrl_i.word.mul_sel)
      MUL_SQUARE: begin op_a = mag;        op_b = VAR_W'(mag);  end
      MUL_ARCH1:  begin op_a = arch_q[0];  op_b = sq_tap[0];    end
      MUL_ARCH2:  begin op_a = arch_q[1];  op_b = sq_tap[1];    end
      MUL_ARCH3:  begin op_a = arch_q[2];  op_b = sq_tap[2];    end
      MUL_GARCH1: begin op_a = garch_q[0]; op_b = var_tap[0];   end
      MUL_GARCH2: begin op_a = garch_q[1]; op_b = var_tap[1];   end
      MUL_GARCH3: begin op_a = garch_q[2]; op_b = var_tap[2];   end
      default:    begin op_a = '0;         op_b = '0;           end
    endcase
  end

  // Final sum already carries the rounding offset from the load step
  assign sum = acc_q + ACC_W'(prod_q);
  assign sat = |sum[ACC_W-1:FRAC_BITS+VAR_W];

  always_comb begin
    case (ctrl_i.word.acc_op)
      ACC_LOAD: acc_d = {(ACC_W-VAR_W-FRAC_BITS)'(0), omega_q,
                         FRAC_BITS'(1) << (FRAC_BITS - 1)};
      ACC_ADD:  acc_d = sum;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      prod_q <= op_a * op_b;
      acc_q  <= acc_d;
      if (ctrl_i.word.capt_sq) begin
        sq_new_q <= prod_q[VAR_W-1:0];
      end
    end
  end

  assign result_o.saturated = sat;
  assign result_o.variance  = sat ? {VAR_W{1'b1}} : sum[FRAC_BITS +: VAR_W];
  assign done_o     = ctrl_i.fire && (ctrl_i.word.acc_op == ACC_DONE);
  assign clear_hist = ctrl_i.fire && (ctrl_i.word.acc_op == ACC_LOAD)
                      && in_data_i.start_series;

  // Delay lines: clear on a series start, shift when a date retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ARCH_ORDER; k++) sq_hist_q[k] <= '0;
      for (int k = 0; k < GARCH_ORDER; k++) var_hist_q[k] <= '0;
    end else if (clear_hist) begin
      for (int k = 0; k < ARCH_ORDER; k++) sq_hist_q[k] <= '0;
      for (int k = 0; k < GARCH_ORDER; k++) var_hist_q[k] <= '0;
    end else if (done_o) begin
      for (int k = ARCH_ORDER - 1; k > 0; k--) sq_hist_q[k] <= sq_hist_q[k-1];
      for (int k = GARCH_ORDER - 1; k > 0; k--) var_hist_q[k] <= var_hist_q[k-1];
      sq_hist_q[0]  <= sq_new_q;
      var_hist_q[0] <= result_o.variance;
    end
  end

endmodule

[hdl/garv_checker.sv]
// ----------------------------------------------------------------------------
// GARCH variance recursion - port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "garch_variance_recursion_top_defines.svh"

module garv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input garv_pkg::garv_out_t           out_data_o
);
  import garv_pkg::*;

  // No result may be shown while or right after reset
  `GARV_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o)

  // A held result keeps its value until taken
  `GARV_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // One item at a time: no new transaction right after an accept
  `GARV_ASSERT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // A clamped result is full scale
  `GARV_ASSERT(a_sat_value, clk_i, rst_ni,
    out_valid_o && out_data_o.saturated |-> out_data_o.variance == {VAR_W{1'b1}})

endmodule

bind garch_variance_recursion_top garv_checker u_garv_checker (.*);

[dv/tb_garch_variance_recursion_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GARCH variance recursion - testbench
// Drives residual samples through valid/ready with random gaps and output
// stalls, and checks every variance against a typed value or a cycle-free
// predictor of the GARCH(3,3) recursion. A directed table covers the field
// extremes, saturation and the start flag. Random series follow under several
// coefficient settings, some of them at the extremes.
// ----------------------------------------------------------------------------
module tb_garch_variance_recursion_top;
  import garv_pkg::*;

  localparam int          LATENCY     = 8;
  localparam int          HOLD_CYCLES = 300;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 50;
  localparam int          NUM_DIR     = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_IDX [7] = '{
    CFG_OMEGA, CFG_ARCH1, CFG_ARCH2, CFG_ARCH3, CFG_GARCH1, CFG_GARCH2, CFG_GARCH3
  };

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] res;
    logic        start;
    logic        known;
    logic [31:0] exp_var;
    logic        exp_sat;
  } dir_row_t;

  // Expected values are typed in only for rows that follow from the settings alone
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // reset settings: all weights zero, history before any start
    '{2'd0, 16'h8000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{2'd0, 16'h7FFF, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{2'd0, 16'hFFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{2'd0, 16'h0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{2'd0, 16'h5555, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    // all registers at maximum: start gives omega, then the sum clamps
    '{2'd1, 16'h7FFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{2'd1, 16'h8000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{2'd1, 16'h0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd1, 16'hAAAA, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd1, 16'h1234, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // typical moderate weights
    '{2'd2, 16'h1000, 1'b1, 1'b1, 32'h0004_0000, 1'b0},
    '{2'd2, 16'h8000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd2, 16'h7FFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd2, 16'h0001, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd2, 16'hFFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd2, 16'h5555, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd2, 16'hAAAA, 1'b1, 1'b1, 32'h0004_0000, 1'b0},
    '{2'd2, 16'h0800, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    // smallest nonzero weights, zero omega
    '{2'd3, 16'h0001, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{2'd3, 16'h8000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd3, 16'h7FFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{2'd3, 16'h0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  garv_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  garv_out_t            out_data_o;

  // Predictor state
  logic [31:0] omega_q;
  logic [15:0] arch_w  [NUM_COEF];
  logic [15:0] garch_w [NUM_COEF];
  logic [31:0] sq_hist  [NUM_COEF];
  logic [31:0] var_hist [NUM_COEF];

  garv_out_t   variance_q [$];
  logic [31:0] cfg_plan [7];
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned errors     = 0;
  int unsigned sent_cnt   = 0;
  int unsigned checked    = 0;
  int unsigned sat_cnt    = 0;
  int unsigned settings   = 0;

  garch_variance_recursion_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [31:0] data);
    case (idx)
      CFG_OMEGA:  omega_q    = data;
      CFG_ARCH1:  arch_w[0]  = data[15:0];
      CFG_ARCH2:  arch_w[1]  = data[15:0];
      CFG_ARCH3:  arch_w[2]  = data[15:0];
      CFG_GARCH1: garch_w[0] = data[15:0];
      CFG_GARCH2: garch_w[1] = data[15:0];
      CFG_GARCH3: garch_w[2] = data[15:0];
      default: ;
    endcase
  endfunction

  // Form the variance of the current date, then push the new lags
  function automatic garv_out_t next_variance(input garv_in_t x);
    int          r;
    logic [31:0] mag;
    logic [31:0] sq;
    logic [63:0] acc;
    logic [63:0] rnd;
    garv_out_t   y;
    r   = $signed(x.residual);
    mag = (r < 0) ? 32'(-r) : 32'(r);
    sq  = mag * mag;
    if (x.start_series) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        sq_hist[k]  = '0;
        var_hist[k] = '0;
      end
    end
    acc = 64'(omega_q) << FRAC_BITS;
    for (int k = 0; k < NUM_COEF; k++) begin
      acc += 64'(arch_w[k]) * 64'(sq_hist[k]);
      acc += 64'(garch_w[k]) * 64'(var_hist[k]);
    end
    rnd = (acc + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (rnd > 64'h0000_0000_FFFF_FFFF) begin
      y.variance  = '1;
      y.saturated = 1'b1;
    end else begin
      y.variance  = rnd[31:0];
      y.saturated = 1'b0;
    end
    for (int k = NUM_COEF - 1; k > 0; k--) begin
      sq_hist[k]  = sq_hist[k-1];
      var_hist[k] = var_hist[k-1];
    end
    sq_hist[0]  = sq;
    var_hist[0] = y.variance;
    return y;
  endfunction

  function automatic void plan_directed(input logic [1:0] phase);
    case (phase)
      2'd1: begin
        foreach (cfg_plan[i]) cfg_plan[i] = 32'hFFFF_FFFF;
      end
      2'd2: begin
        cfg_plan = '{32'h0004_0000, 32'hA5A5_0CCD, 32'h5A5A_0666, 32'hFFFF_0333,
                     32'h8000_6666, 32'h0001_0800, 32'h7FFF_0400};
      end
      default: begin
        cfg_plan[0] = 32'h0000_0000;
        for (int i = 1; i < 7; i++) cfg_plan[i] = 32'hFFFF_0001;
      end
    endcase
  endfunction

  // Upper halves of the weight writes carry random or all-one bits that must be dropped
  function automatic void plan_random(input int mode);
    case (mode)
      0: begin
        cfg_plan[0] = $urandom_range(0, 32'h0100_0000);
        for (int i = 1; i < 4; i++) cfg_plan[i] = {16'($urandom), 16'($urandom_range(0, 16'h1000))};
        cfg_plan[4] = {16'($urandom), 16'($urandom_range(0, 16'h5000))};
        cfg_plan[5] = {16'($urandom), 16'($urandom_range(0, 16'h0800))};
        cfg_plan[6] = {16'($urandom), 16'($urandom_range(0, 16'h0800))};
      end
      1: begin
        foreach (cfg_plan[i]) cfg_plan[i] = $urandom;
      end
      2: begin
        foreach (cfg_plan[i]) cfg_plan[i] = 32'hFFFF_FFFF;
      end
      default: begin
        cfg_plan[0] = $urandom_range(0, 3);
        for (int i = 1; i < 7; i++) cfg_plan[i] = {16'($urandom), 16'($urandom_range(0, 1))};
      end
    endcase
  endfunction

  task automatic apply_settings();
    for (int i = 0; i < 7; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= REG_IDX[i];
      cfg_wdata_i <= cfg_plan[i];
      store_setting(REG_IDX[i], cfg_plan[i]);
    end
    // index past the last register: must leave every weight alone
    @(negedge clk_i);
    cfg_idx_i   <= CFG_UNUSED;
    cfg_wdata_i <= $urandom;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic send_item(input garv_in_t item, input bit known, input garv_out_t typed);
    int unsigned gap;
    garv_out_t   pred;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pred = next_variance(item);
    variance_q.push_back(known ? typed : pred);
    sent_cnt++;
  endtask

  // Hold the input until every pending variance has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (variance_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned wait_cyc;
    garv_out_t   want;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        wait_cyc = rx_idle_on ? $urandom_range(0, 4) : 0;
        if (wait_cyc > 0) begin
          out_ready_i <= 1'b0;
          repeat (wait_cyc) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (variance_q.size() == 0) begin
        $error("variance %h arrived with no pending transaction", out_data_o.variance);
        errors++;
      end else begin
        want = variance_q.pop_front();
        if (out_data_o.variance !== want.variance) begin
          $error("variance: expected %h, got %h", want.variance, out_data_o.variance);
          errors++;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, out_data_o.saturated);
          errors++;
        end
        if (want.saturated) sat_cnt++;
        checked++;
      end
    end
  end

  initial begin : stimulus
    logic [1:0]  cur_phase;
    garv_in_t    item;
    garv_out_t   typed;
    int unsigned series_left;
    int          pick;
    int          val;
    omega_q = '0;
    for (int k = 0; k < NUM_COEF; k++) begin
      arch_w[k]   = '0;
      garch_w[k]  = '0;
      sq_hist[k]  = '0;
      var_hist[k] = '0;
    end
    series_left = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cur_phase = 2'd0;
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].phase != cur_phase) begin
        drain();
        cur_phase = DIR_ROWS[i].phase;
        plan_directed(cur_phase);
        apply_settings();
      end
      item.residual     = DIR_ROWS[i].res;
      item.start_series = DIR_ROWS[i].start;
      typed.variance    = DIR_ROWS[i].exp_var;
      typed.saturated   = DIR_ROWS[i].exp_sat;
      send_item(item, DIR_ROWS[i].known, typed);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      plan_random(p % 4);
      apply_settings();
      // every third phase runs back to back on both sides
      tx_idle_on = (p % 3) != 1;
      rx_idle_on = (p % 3) != 1;
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          item.residual = 16'($urandom);
        end else if (pick < 8) begin
          val = int'($urandom_range(0, 4095)) - 2048;
          item.residual = 16'(val);
        end else begin
          case ($urandom_range(0, 4))
            0:       item.residual = 16'h8000;
            1:       item.residual = 16'h7FFF;
            2:       item.residual = 16'hFFFF;
            3:       item.residual = 16'h0001;
            default: item.residual = 16'h0000;
          endcase
        end
        // mostly whole series opened by a start flag, with stray starts as noise
        if (series_left == 0) begin
          item.start_series = 1'b1;
          series_left = $urandom_range(1, 40) - 1;
        end else begin
          item.start_series = ($urandom_range(0, 19) == 0);
          series_left--;
        end
        send_item(item, 1'b0, '0);
      end
    end
    drain();

    $display("tb: %0d samples sent, %0d variances checked (%0d clamped), %0d settings",
             sent_cnt, checked, sat_cnt, settings);
    $display("tb: %0d mismatches after directed extremes and random series", errors);
    if (errors == 0 && variance_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
